>>> design/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlpt_pkg;

	localparam int NUM_TABLES        = 16;
	localparam int ENTRIES_PER_TABLE = 1024;
	localparam int DIR_DEPTH         = 1024;

	localparam int DIR_AW     = $clog2(DIR_DEPTH);
	localparam int PT_AW      = $clog2(ENTRIES_PER_TABLE);
	localparam int TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int NFT_W      = $clog2(NUM_TABLES + 1);
	localparam int POOL_DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
	localparam int POOL_AW    = $clog2(POOL_DEPTH);
	localparam int FRAME_W    = 20;
	localparam int OFF_W      = 12;
	localparam int DIR_W      = TBL_W + 1;
	localparam int PTE_W      = FRAME_W + 1;

	localparam int Q_AW    = 1;
	localparam int Q_DEPTH = 1 << Q_AW;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_PASS = 2'd0;
	localparam kind_t KIND_WALK = 2'd1;
	localparam kind_t KIND_MAP  = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t STS_OK       = 2'd0;
	localparam status_t STS_UNMAPPED = 2'd1;
	localparam status_t STS_NO_TABLE = 2'd2;
	localparam status_t STS_ALREADY  = 2'd3;

	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_MAP       = 1'b1;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] va;
		logic [31:0] pa;
	} cmd_t;

endpackage

`default_nettype wire

>>> design/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine
// Two-level page table walker with in-order table allocation on map.
//
//   channel  handshake            payload
//   input    push / full          opcode, virt_addr, phys_addr
//   result   empty / pop          result_addr, status
//   config   cfg_we               cfg_data (paging_enabled)
//
// Pass-through translate is answered from the idle state. Walk or map goes
// through the registered directory read, then the page table read if needed.
// After reset a clearing pass writes every entry of both memories; full
// stays high meanwhile, config writes are still taken.
// A two-entry command queue and a two-entry result queue decouple the sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_table_engine import tlpt_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_data,
	input  wire         push,
	output logic        full,
	input  wire         opcode,
	input  wire  [31:0] virt_addr,
	input  wire  [31:0] phys_addr,
	output logic        empty,
	input  wire         pop,
	output logic [31:0] result_addr,
	output logic [1:0]  status
);

	logic busy;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	tlpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.virt_addr (virt_addr),
		.phys_addr (phys_addr),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tlpt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.busy        (busy),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.result_addr (result_addr),
		.status      (status)
	);

endmodule

`default_nettype wire

>>> design/tlpt_ram.sv
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/tlpt_front.sv
// ----------------------------------------------------------------------------
// tlpt_front
// Accepts items, classifies them against the paging mode and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlpt_front import tlpt_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_data,
	input  wire         push,
	output logic        full,
	input  wire         opcode,
	input  wire  [31:0] virt_addr,
	input  wire  [31:0] phys_addr,
	input  wire         busy,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  wire         cmd_pop
);

	logic            paging_q;
	cmd_t            q_data_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q;
	logic [Q_AW-1:0] rp_q;
	logic [Q_AW:0]   cnt_q;
	logic            acc;
	logic            deq;
	cmd_t            in_cmd;

	assign full      = busy || (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign acc       = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign deq       = cmd_pop && cmd_valid;
	assign cmd       = q_data_q[rp_q];

	always_comb begin
		in_cmd.va = virt_addr;
		in_cmd.pa = phys_addr;
		if (opcode == OP_MAP) begin
			in_cmd.kind = KIND_MAP;
		end else if (paging_q) begin
			in_cmd.kind = KIND_WALK;
		end else begin
			in_cmd.kind = KIND_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q <= 1'b0;
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				paging_q <= cfg_data;
			end
			if (acc) begin
				wp_q <= wp_q + 1'b1;
			end
			if (deq) begin
				rp_q <= rp_q + 1'b1;
			end
			if (acc && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!acc && deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			q_data_q[wp_q] <= in_cmd;
		end
	end

endmodule

`default_nettype wire

>>> design/tlpt_back.sv
// ----------------------------------------------------------------------------
// tlpt_back
// Walks directory and page table memories, allocates tables, queues results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlpt_back import tlpt_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	output logic        busy,
	input  wire         cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        empty,
	input  wire         pop,
	output logic [31:0] result_addr,
	output logic [1:0]  status
);

	localparam logic [1:0] S_CLR  = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_DIR  = 2'd2;
	localparam logic [1:0] S_TBL  = 2'd3;

	logic [1:0]         state_q;
	logic [1:0]         state_d;
	logic [POOL_AW-1:0] clr_q;
	logic [NFT_W-1:0]   nft_q;
	cmd_t               cur_q;
	logic [POOL_AW-1:0] slot_q;
	logic [POOL_AW-1:0] slot_d;

	logic               dir_we;
	logic [DIR_AW-1:0]  dir_waddr;
	logic [DIR_W-1:0]   dir_wdata;
	logic               dir_re;
	logic [DIR_W-1:0]   dir_rdata;
	logic               pool_we;
	logic [POOL_AW-1:0] pool_waddr;
	logic [PTE_W-1:0]   pool_wdata;
	logic               pool_re;
	logic [PTE_W-1:0]   pool_rdata;

	logic               take;
	logic               alloc;
	logic               res_push;
	logic [31:0]        res_addr_d;
	status_t            res_sts_d;

	logic [31:0]        res_addr_q [Q_DEPTH];
	status_t            res_sts_q  [Q_DEPTH];
	logic [Q_AW-1:0]    res_wp_q;
	logic [Q_AW-1:0]    res_rp_q;
	logic [Q_AW:0]      res_cnt_q;
	logic               res_pop;

	logic [PT_AW-1:0]   ti;
	logic               dir_p;
	logic [TBL_W-1:0]   dir_t;
	logic [TBL_W-1:0]   new_t;

	assign busy    = (state_q == S_CLR);
	assign ti      = cur_q.va[OFF_W+PT_AW-1:OFF_W];
	assign dir_p   = dir_rdata[TBL_W];
	assign dir_t   = dir_rdata[TBL_W-1:0];
	assign new_t   = nft_q[TBL_W-1:0];
	assign empty   = (res_cnt_q == '0);
	assign res_pop = pop && !empty;
	assign result_addr = res_addr_q[res_rp_q];
	assign status      = res_sts_q[res_rp_q];

	always_comb begin
		state_d    = state_q;
		take       = 1'b0;
		alloc      = 1'b0;
		cmd_pop    = 1'b0;
		dir_we     = 1'b0;
		dir_waddr  = cur_q.va[31:32-DIR_AW];
		dir_wdata  = {1'b1, new_t};
		dir_re     = 1'b0;
		pool_we    = 1'b0;
		pool_waddr = slot_q;
		pool_wdata = {1'b1, cur_q.pa[31:OFF_W]};
		pool_re    = 1'b0;
		slot_d     = POOL_AW'({dir_t, ti});
		res_push   = 1'b0;
		res_addr_d = '0;
		res_sts_d  = STS_OK;
		case (state_q)
			S_CLR: begin
				pool_we    = 1'b1;
				pool_waddr = clr_q;
				pool_wdata = '0;
				dir_we     = ({1'b0, clr_q} < (POOL_AW+1)'(DIR_DEPTH));
				dir_waddr  = clr_q[DIR_AW-1:0];
				dir_wdata  = '0;
				if (clr_q == POOL_AW'(POOL_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_valid && (res_cnt_q != (Q_AW+1)'(Q_DEPTH))) begin
					cmd_pop = 1'b1;
					if (cmd.kind == KIND_PASS) begin
						res_push   = 1'b1;
						res_addr_d = cmd.va;
					end else begin
						take    = 1'b1;
						dir_re  = 1'b1;
						state_d = S_DIR;
					end
				end
			end
			S_DIR: begin
				if (cur_q.kind == KIND_WALK) begin
					if (!dir_p) begin
						res_push  = 1'b1;
						res_sts_d = STS_UNMAPPED;
						state_d   = S_IDLE;
					end else begin
						pool_re = 1'b1;
						state_d = S_TBL;
					end
				end else if (dir_p) begin
					pool_re = 1'b1;
					state_d = S_TBL;
				end else if (nft_q >= NFT_W'(NUM_TABLES)) begin
					res_push  = 1'b1;
					res_sts_d = STS_NO_TABLE;
					state_d   = S_IDLE;
				end else begin
					// fresh table: entry is known empty
					alloc      = 1'b1;
					dir_we     = 1'b1;
					pool_we    = 1'b1;
					pool_waddr = POOL_AW'({new_t, ti});
					res_push   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_TBL: begin
				res_push = 1'b1;
				state_d  = S_IDLE;
				if (cur_q.kind == KIND_WALK) begin
					if (pool_rdata[FRAME_W]) begin
						res_addr_d = {pool_rdata[FRAME_W-1:0], cur_q.va[OFF_W-1:0]};
					end else begin
						res_sts_d = STS_UNMAPPED;
					end
				end else if (pool_rdata[FRAME_W]) begin
					res_sts_d = STS_ALREADY;
				end else begin
					pool_we = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			nft_q     <= '0;
			res_wp_q  <= '0;
			res_rp_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (alloc) begin
				nft_q <= nft_q + 1'b1;
			end
			if (res_push) begin
				res_wp_q <= res_wp_q + 1'b1;
			end
			if (res_pop) begin
				res_rp_q <= res_rp_q + 1'b1;
			end
			if (res_push && !res_pop) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (!res_push && res_pop) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= cmd;
		end
		if (pool_re) begin
			slot_q <= slot_d;
		end
		if (res_push) begin
			res_addr_q[res_wp_q] <= res_addr_d;
			res_sts_q[res_wp_q]  <= res_sts_d;
		end
	end

	tlpt_ram #(
		.WIDTH (DIR_W),
		.DEPTH (DIR_DEPTH)
	) u_dir (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.re    (dir_re),
		.raddr (cmd.va[31:32-DIR_AW]),
		.rdata (dir_rdata)
	);

	tlpt_ram #(
		.WIDTH (PTE_W),
		.DEPTH (POOL_DEPTH)
	) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.re    (pool_re),
		.raddr (slot_d),
		.rdata (pool_rdata)
	);

endmodule

`default_nettype wire

>>> tb/two_level_page_table_engine_tb.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine_tb
// Checks the engine's map and translate items against a cycle-free model of
// the directory, the table pool and in-order table allocation. Directed items
// cover the address extremes, frame zero, unaligned frames, remapping and
// pool exhaustion; random translates often revisit mapped pages, with idling
// and back-pressure on both queue sides and paging switched between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_page_table_engine_tb;
	import tlpt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOT_N       = 20;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic [31:0] addr;
		status_t     sts;
	} xlat_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_data;
	logic        push;
	logic        full;
	logic        opcode;
	logic [31:0] virt_addr;
	logic [31:0] phys_addr;
	logic        empty;
	logic        pop;
	logic [31:0] result_addr;
	logic [1:0]  status;

	// model state
	bit                  dir_present [DIR_DEPTH];
	int unsigned         dir_table   [DIR_DEPTH];
	bit                  pte_present [POOL_DEPTH];
	bit [FRAME_W-1:0]    pte_frame   [POOL_DEPTH];
	int unsigned         tables_used;
	bit                  paging_on;

	xlat_result_t        xlat_expected[$];
	xlat_result_t        head_result;
	logic [31:0]         mapped_pages[$];
	logic [DIR_AW-1:0]   hot_dirs[HOT_N];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_seen;
	int hold_left;
	int mismatches;
	int cycle_count;

	two_level_page_table_engine u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.virt_addr   (virt_addr),
		.phys_addr   (phys_addr),
		.empty       (empty),
		.pop         (pop),
		.result_addr (result_addr),
		.status      (status)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic xlat_result_t walk_predict(logic op, logic [31:0] va, logic [31:0] pa);
		xlat_result_t      res;
		logic [DIR_AW-1:0] di;
		logic [PT_AW-1:0]  ti;
		int unsigned       slot;
		di       = va[31:22];
		ti       = va[21:12];
		res.addr = '0;
		res.sts  = STS_OK;
		if (op == OP_TRANSLATE) begin
			if (!paging_on) begin
				res.addr = va;
			end else if (!dir_present[di]) begin
				res.sts = STS_UNMAPPED;
			end else begin
				slot = dir_table[di] * ENTRIES_PER_TABLE + ti;
				if (!pte_present[slot])
					res.sts = STS_UNMAPPED;
				else
					res.addr = {pte_frame[slot], va[11:0]};
			end
		end else begin
			if (!dir_present[di]) begin
				if (tables_used >= NUM_TABLES) begin
					res.sts = STS_NO_TABLE;
				end else begin
					dir_present[di] = 1'b1;
					dir_table[di]   = tables_used;
					tables_used++;
				end
			end
			if (res.sts == STS_OK) begin
				slot = dir_table[di] * ENTRIES_PER_TABLE + ti;
				if (pte_present[slot]) begin
					res.sts = STS_ALREADY;
				end else begin
					pte_present[slot] = 1'b1;
					pte_frame[slot]   = pa[31:12];
				end
			end
		end
		return res;
	endfunction

	function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
	endfunction

	task automatic push_request(input logic op, input logic [31:0] va, input logic [31:0] pa);
		xlat_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push      = 1'b1;
		opcode    = op;
		virt_addr = va;
		phys_addr = pa;
		@(posedge clk);
		while (full)
			@(posedge clk);
		res = walk_predict(op, va, pa);
		xlat_expected.push_back(res);
		if (op == OP_MAP && res.sts == STS_OK)
			mapped_pages.push_back(va);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push = 1'b0;
		while (xlat_expected.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_paging(input logic en);
		wait_drained();
		cfg_we   = 1'b1;
		cfg_data = en;
		@(negedge clk);
		cfg_we    = 1'b0;
		paging_on = en;
	endtask

	task automatic random_request();
		logic        op;
		logic [31:0] va;
		logic [31:0] r;
		logic [31:0] page;
		int          pick;
		op   = ($urandom_range(99) < 35) ? OP_MAP : OP_TRANSLATE;
		r    = $urandom;
		pick = $urandom_range(99);
		if (op == OP_TRANSLATE && mapped_pages.size() > 0 && pick < 60) begin
			page = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
			va   = {page[31:12], r[11:0]};
		end else if (pick < 90) begin
			if ($urandom_range(3) == 0)
				va = {hot_dirs[$urandom_range(HOT_N - 1)], r[21:0]};
			else
				va = {hot_dirs[$urandom_range(HOT_N - 1)], 5'd0, r[16:12], r[11:0]};
		end else begin
			va = r;
		end
		push_request(op, va, $urandom);
	endtask

	task automatic test_directed();
		// paging off: identity, but maps still land in the tables
		push_request(OP_TRANSLATE, 32'h0000_0000, 32'hFFFF_FFFF);
		push_request(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000);
		push_request(OP_MAP,       32'h0000_0000, 32'h0000_0000);
		push_request(OP_MAP,       32'hFFFF_F000, 32'hFFFF_FFFF);
		push_request(OP_TRANSLATE, 32'h0000_0123, 32'h0000_0000);
		write_paging(1'b1);
		push_request(OP_TRANSLATE, 32'h0000_0ABC, 32'h0000_0000);
		push_request(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000);
		push_request(OP_TRANSLATE, 32'h0000_1000, 32'h0000_0000);
		push_request(OP_TRANSLATE, 32'h0040_0000, 32'h0000_0000);
		push_request(OP_MAP,       32'h0000_0000, 32'h1234_5000);
		push_request(OP_TRANSLATE, 32'h0000_0FFF, 32'h0000_0000);
		push_request(OP_MAP,       32'h0000_1000, 32'hABCD_E123);
		push_request(OP_TRANSLATE, 32'h0000_1555, 32'h0000_0000);
		push_request(OP_MAP,       32'h0040_0FFF, 32'h5555_5000);
		push_request(OP_TRANSLATE, 32'h0040_0AAA, 32'hFFFF_FFFF);
		push_request(OP_MAP,       32'hFFFF_FFFF, 32'h0000_0000);
		push_request(OP_TRANSLATE, 32'hFFFF_E001, 32'h0000_0000);
	endtask

	task automatic test_random_phase(input int n);
		repeat (n) random_request();
	endtask

	// receiver stops for a long stretch while items keep coming
	task automatic test_backpressure();
		@(negedge clk);
		hold_requests++;
		repeat (24) random_request();
	endtask

	task automatic test_drain_pause();
		repeat (10) random_request();
		wait_drained();
		repeat (10) random_request();
	endtask

	task automatic test_pool_exhaustion();
		logic [DIR_AW-1:0] d;
		int                guard;
		int                free_dir;
		logic [31:0]       r;
		guard = 0;
		while (tables_used < NUM_TABLES && guard < 4096) begin
			d = DIR_AW'($urandom);
			r = $urandom;
			if (!dir_present[d])
				push_request(OP_MAP, {d, r[21:0]}, $urandom);
			guard++;
		end
		free_dir = 0;
		for (int i = 0; i < DIR_DEPTH; i++) begin
			if (!dir_present[i]) begin
				free_dir = i;
				break;
			end
		end
		push_request(OP_MAP,       {free_dir[9:0], 22'h2A5_5A5}, 32'h7654_3210);
		push_request(OP_TRANSLATE, {free_dir[9:0], 22'h2A5_5A5}, 32'h0000_0000);
		push_request(OP_MAP,       {free_dir[9:0], 22'h000_000}, 32'h0000_1000);
		push_request(OP_MAP,       32'h0000_2000, 32'h0BAD_F000);
		push_request(OP_TRANSLATE, 32'h0000_2FED, 32'h0000_0000);
	endtask

	// result side: random pop, with a long hold-off on request
	initial begin
		pop       = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop = 1'b0;
			end else begin
				pop = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (xlat_expected.size() == 0) begin
				flag_mismatch("unexpected item", 32'h0, result_addr);
			end else begin
				head_result = xlat_expected.pop_front();
				if (result_addr !== head_result.addr)
					flag_mismatch("result_addr", head_result.addr, result_addr);
				if (status !== head_result.sts)
					flag_mismatch("status", {30'd0, head_result.sts}, {30'd0, status});
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_data      = 1'b0;
		push          = 1'b0;
		opcode        = OP_TRANSLATE;
		virt_addr     = '0;
		phys_addr     = '0;
		send_idle_pct = 26;
		recv_idle_pct = 65;
		hold_requests = 0;
		mismatches    = 0;
		tables_used   = 0;
		paging_on     = 1'b0;
		hot_dirs[0]   = '0;
		hot_dirs[1]   = '1;
		for (int i = 2; i < HOT_N; i++)
			hot_dirs[i] = DIR_AW'($urandom_range(DIR_DEPTH - 2, 1));
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_paging(1'b0);
		test_directed();

		send_idle_pct = 26;
		recv_idle_pct = 65;
		test_random_phase(130);

		send_idle_pct = 65;
		recv_idle_pct = 26;
		write_paging(1'b0);
		test_random_phase(60);
		write_paging(1'b1);
		test_random_phase(70);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_drain_pause();
		test_random_phase(90);
		test_pool_exhaustion();
		write_paging(1'b0);
		test_random_phase(20);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && xlat_expected.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> two_level_page_table_engine.f
design/tlpt_pkg.sv
design/tlpt_ram.sv
design/tlpt_front.sv
design/tlpt_back.sv
design/two_level_page_table_engine.sv
tb/two_level_page_table_engine_tb.sv
